// ----- rtl/cbz_pkg.sv -----
// Shared constants for the cubic Bezier point evaluator.
`timescale 1ns / 1ps

package cbz_pkg;

	localparam int NUM_REGS  = 8;
	localparam int CFG_IDX_W = 3;

	// Register indexes of the control point coordinates.
	localparam logic [CFG_IDX_W-1:0] REG_P0_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_P0_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_P1_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_P1_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_P2_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_P2_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_P3_X = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_P3_Y = 3'd7;

	// Register stages from input beat to result register.
	localparam int PIPE_STAGES = 6;

	// Number of coordinate axes.
	localparam int NUM_AXES = 2;

endpackage

// ----- rtl/cbz_lerp_cell.sv -----
// One interpolation cell: registers u*a and t*b, then their sum.
`timescale 1ns / 1ps

module cbz_lerp_cell #(
	parameter int IN_W = 10,
	parameter int T_W  = 11
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic [T_W-1:0]          t,
	input  logic [T_W-1:0]          u,
	input  logic [IN_W-1:0]         a,
	input  logic [IN_W-1:0]         b,
	output logic [IN_W+T_W-2:0]     sum
);

	localparam int PROD_W = IN_W + T_W;
	localparam int OUT_W  = IN_W + T_W - 1;

	logic [PROD_W-1:0] pa_s1;
	logic [PROD_W-1:0] pb_s1;
	logic [PROD_W-1:0] full_sum;
	logic [OUT_W-1:0]  sum_s2;

	// The sum never exceeds (2^IN_W - 1) * 2^(T_W - 1), so the top bit is dropped.
	assign full_sum = pa_s1 + pb_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1  <= PROD_W'(u) * PROD_W'(a);
			pb_s1  <= PROD_W'(t) * PROD_W'(b);
			sum_s2 <= full_sum[OUT_W-1:0];
		end
	end

	assign sum = sum_s2;

endmodule

// ----- rtl/cubic_bezier_de_casteljau_point.sv -----
// Top level of the cubic Bezier point evaluator built from a row of interpolation cells.
`timescale 1ns / 1ps
// A result is valid once its accepted input beat has passed six register stages.
// Throughput: one beat per cycle; the whole row of cells holds only while a result waits.
// Each of the three interpolation levels costs two stages: products, then their sum.
// Reset clears the control points to zero and empties the pipeline; no clearing pass is needed.

module cubic_bezier_de_casteljau_point #(
	parameter int COORD_BITS  = 10,
	parameter int T_FRAC_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wen,
	input  logic [cbz_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0]          cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [T_FRAC_BITS:0]           t,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [COORD_BITS-1:0]          x,
	output logic [COORD_BITS-1:0]          y
);

	localparam int T_W = T_FRAC_BITS + 1;
	localparam int W1  = COORD_BITS + T_FRAC_BITS;
	localparam int W2  = COORD_BITS + 2 * T_FRAC_BITS;
	localparam int W3  = COORD_BITS + 3 * T_FRAC_BITS;
	localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;

	logic [COORD_BITS-1:0] cfg_q [cbz_pkg::NUM_REGS];
	logic [cbz_pkg::PIPE_STAGES-1:0] valid_q;
	logic                  en;
	logic [T_W-1:0]        t_sat;
	logic [T_W-1:0]        u_sat;
	logic [T_W-1:0]        t_s1, t_s2, t_s3, t_s4;
	logic [T_W-1:0]        u_s1, u_s2, u_s3, u_s4;

	logic [COORD_BITS-1:0] ctl  [cbz_pkg::NUM_AXES][4];
	logic [W1-1:0]         lvl1 [cbz_pkg::NUM_AXES][3];
	logic [W2-1:0]         lvl2 [cbz_pkg::NUM_AXES][2];
	logic [W3-1:0]         lvl3 [cbz_pkg::NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cbz_pkg::NUM_REGS; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg_wen) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// The row advances unless a finished result is held back.
	assign en        = !(valid_q[cbz_pkg::PIPE_STAGES-1] && out_stall);
	assign in_stall  = !en;
	assign out_valid = valid_q[cbz_pkg::PIPE_STAGES-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (en) begin
			valid_q <= {valid_q[cbz_pkg::PIPE_STAGES-2:0], in_valid};
		end
	end

	// A parameter above one saturates to one.
	assign t_sat = (t > T_ONE) ? T_ONE : t;
	assign u_sat = T_ONE - t_sat;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1 <= t_sat;
			u_s1 <= u_sat;
			t_s2 <= t_s1;
			u_s2 <= u_s1;
			t_s3 <= t_s2;
			u_s3 <= u_s2;
			t_s4 <= t_s3;
			u_s4 <= u_s3;
		end
	end

	assign ctl[0][0] = cfg_q[cbz_pkg::REG_P0_X];
	assign ctl[0][1] = cfg_q[cbz_pkg::REG_P1_X];
	assign ctl[0][2] = cfg_q[cbz_pkg::REG_P2_X];
	assign ctl[0][3] = cfg_q[cbz_pkg::REG_P3_X];
	assign ctl[1][0] = cfg_q[cbz_pkg::REG_P0_Y];
	assign ctl[1][1] = cfg_q[cbz_pkg::REG_P1_Y];
	assign ctl[1][2] = cfg_q[cbz_pkg::REG_P2_Y];
	assign ctl[1][3] = cfg_q[cbz_pkg::REG_P3_Y];

	for (genvar ax = 0; ax < cbz_pkg::NUM_AXES; ax++) begin : g_axis
		for (genvar c = 0; c < 3; c++) begin : g_lvl1
			cbz_lerp_cell #(.IN_W(COORD_BITS), .T_W(T_W)) u_cell (
				.clk (clk),
				.en  (en),
				.t   (t_sat),
				.u   (u_sat),
				.a   (ctl[ax][c]),
				.b   (ctl[ax][c+1]),
				.sum (lvl1[ax][c])
			);
		end
		for (genvar c = 0; c < 2; c++) begin : g_lvl2
			cbz_lerp_cell #(.IN_W(W1), .T_W(T_W)) u_cell (
				.clk (clk),
				.en  (en),
				.t   (t_s2),
				.u   (u_s2),
				.a   (lvl1[ax][c]),
				.b   (lvl1[ax][c+1]),
				.sum (lvl2[ax][c])
			);
		end
		cbz_lerp_cell #(.IN_W(W2), .T_W(T_W)) u_cell3 (
			.clk (clk),
			.en  (en),
			.t   (t_s4),
			.u   (u_s4),
			.a   (lvl2[ax][0]),
			.b   (lvl2[ax][1]),
			.sum (lvl3[ax])
		);
	end

	// Dropping the fractional bits floors the point to whole pixels.
	assign x = lvl3[0][W3-1 -: COORD_BITS];
	assign y = lvl3[1][W3-1 -: COORD_BITS];

endmodule

// ----- rtl/cbz_checker.sv -----
// Port-level checker for the cubic Bezier point evaluator, bound to the top level.
`timescale 1ns / 1ps

module cbz_checker #(
	parameter int COORD_BITS  = 10
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [COORD_BITS-1:0] x,
	input logic [COORD_BITS-1:0] y
);

	// A held result beat keeps its valid and its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(x) && $stable(y))
		else $error("result beat changed while stalled");

	// The input side stalls only when a result is held back.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// With the output free, an accepted beat yields a result once it has passed the pipeline.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall
		##1 !out_stall ##1 !out_stall ##1 !out_stall |=> out_valid)
		else $error("result missing after pipeline latency");

	// A result can only appear when the pipeline moved in the previous cycle.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_stall))
		else $error("result appeared while pipeline was held");

endmodule

bind cubic_bezier_de_casteljau_point cbz_checker #(
	.COORD_BITS  (COORD_BITS)
) u_cbz_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.x         (x),
	.y         (y)
);
